[src/sshp_pkg.sv]
// Shared types and constants for the stream-set header parser.
// Depends on nothing; every other file but sshp_if refers to it by scoped names.
package sshp_pkg;

	localparam logic [31:0] VERSION_RESET = 32'd20090218;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TRUNC    = 3'd1;
	localparam logic [2:0] ST_OVERLONG = 3'd2;
	localparam logic [2:0] ST_VERSION  = 3'd3;
	localparam logic [2:0] ST_TOO_MANY = 3'd4;
	localparam logic [2:0] ST_MISMATCH = 3'd5;

	// Controller to datapath.
	typedef struct packed {
		logic       take_byte;
		logic       take_count;
		logic       take_length;
		logic       take_payload;
		logic       set_err;
		logic [2:0] err_code;
		logic       clear_run;
		logic       load_single;
		logic [2:0] single_code;
		logic       emit_start;
		logic       load_entry;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic       byte_more;
		logic       digit_full;
		logic       version_ok;
		logic       count_over;
		logic       field_zero;
		logic       lengths_last;
		logic       count_zero_q;
		logic       size_ok_inc;
		logic       size_ok_len;
		logic       emit_last;
		logic       out_free;
		logic [2:0] err_code_q;
	} sts_t;

endpackage

[src/sshp_if.sv]
// Handshake channels of the stream-set header parser: input bytes,
// result items and the version register write port. Uses no package.
interface sshp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface sshp_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        entry_valid;
	logic [3:0]  stream_index;
	logic [31:0] stream_offset;
	logic [31:0] stream_length;
	logic        last;

	modport source(output valid, output status, output entry_valid, output stream_index,
		output stream_offset, output stream_length, output last, input ready);
	modport sink(input valid, input status, input entry_valid, input stream_index,
		input stream_offset, input stream_length, input last, output ready);
endinterface

interface sshp_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] expected_version;

	modport source(output valid, output expected_version, input ready);
	modport sink(input valid, input expected_version, output ready);
endinterface

[src/sshp_ctrl.sv]
// Parse-phase and emission controller of the stream-set header parser.
// Depends on sshp_pkg for the command and status structs and status codes.
module sshp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          last_byte,
	input  sshp_pkg::sts_t sts,
	output logic          in_ready,
	output sshp_pkg::cmd_t cmd
);

	localparam logic [2:0] PH_VERSION = 3'd0;
	localparam logic [2:0] PH_COUNT   = 3'd1;
	localparam logic [2:0] PH_LENGTHS = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_ERROR   = 3'd4;
	localparam logic [2:0] PH_EMIT_RD = 3'd5;
	localparam logic [2:0] PH_EMIT_LD = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       accept;
	logic       size_ok;
	logic       zero_streams;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		size_ok      = 1'b1;
		zero_streams = 1'b0;
		in_ready     = (state_q inside {PH_VERSION, PH_COUNT, PH_LENGTHS, PH_PAYLOAD,
			PH_ERROR}) && sts.out_free;
		accept       = in_valid && in_ready;

		case (state_q)
			PH_VERSION, PH_COUNT, PH_LENGTHS: begin
				if (accept) begin
					cmd.take_byte = 1'b1;
					if (sts.byte_more) begin
						if (sts.digit_full) begin
							cmd.set_err  = 1'b1;
							cmd.err_code = sshp_pkg::ST_OVERLONG;
							state_d      = PH_ERROR;
						end
					end else if (state_q == PH_VERSION) begin
						if (sts.version_ok) begin
							state_d = PH_COUNT;
						end else begin
							cmd.set_err  = 1'b1;
							cmd.err_code = sshp_pkg::ST_VERSION;
							state_d      = PH_ERROR;
						end
					end else if (state_q == PH_COUNT) begin
						if (sts.count_over) begin
							cmd.set_err  = 1'b1;
							cmd.err_code = sshp_pkg::ST_TOO_MANY;
							state_d      = PH_ERROR;
						end else begin
							cmd.take_count = 1'b1;
							// A count of zero skips the length field.
							if (sts.field_zero) begin
								zero_streams = 1'b1;
								state_d      = PH_PAYLOAD;
							end else begin
								state_d = PH_LENGTHS;
							end
						end
					end else begin
						cmd.take_length = 1'b1;
						if (sts.lengths_last) begin
							state_d = PH_PAYLOAD;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				if (accept) begin
					cmd.take_payload = 1'b1;
				end
			end
			PH_ERROR: begin
			end
			PH_EMIT_RD: begin
				state_d = PH_EMIT_LD;
			end
			PH_EMIT_LD: begin
				if (sts.out_free) begin
					cmd.load_entry = 1'b1;
					if (sts.emit_last) begin
						cmd.clear_run = 1'b1;
						state_d       = PH_VERSION;
					end else begin
						state_d = PH_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = PH_VERSION;
			end
		endcase

		if (accept && last_byte) begin
			if (state_q == PH_PAYLOAD) begin
				size_ok = sts.size_ok_inc;
			end else if (state_q == PH_LENGTHS) begin
				size_ok = sts.size_ok_len;
			end
			if (state_d == PH_ERROR) begin
				cmd.single_code = cmd.set_err ? cmd.err_code : sts.err_code_q;
			end else if (state_d != PH_PAYLOAD) begin
				cmd.single_code = sshp_pkg::ST_TRUNC;
			end else if (!size_ok) begin
				cmd.single_code = sshp_pkg::ST_MISMATCH;
			end else if (zero_streams || (state_q == PH_PAYLOAD && sts.count_zero_q)) begin
				cmd.single_code = sshp_pkg::ST_OK;
			end else begin
				cmd.emit_start = 1'b1;
			end
			if (cmd.emit_start) begin
				state_d = PH_EMIT_RD;
			end else begin
				cmd.load_single = 1'b1;
				cmd.clear_run   = 1'b1;
				state_d         = PH_VERSION;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_VERSION;
		end else begin
			state_q <= state_d;
		end
	end

	a_emit_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PH_EMIT_RD || state_q == PH_EMIT_LD) |-> !in_ready)
		else $error("input accepted during emission");

	a_single_or_entry: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_single && cmd.load_entry))
		else $error("two result loads in one cycle");

	a_single_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_single |-> (in_valid && in_ready && last_byte))
		else $error("single result without a last byte");

	a_read_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == PH_EMIT_RD |=> state_q == PH_EMIT_LD)
		else $error("table read not followed by load");

endmodule

[src/sshp_dp.sv]
// Datapath of the stream-set header parser: varint accumulator, counters,
// length table memory, version register and result register. Uses sshp_pkg.
module sshp_dp #(
	parameter int MAX_STREAMS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     data_byte,
	input  logic           cfg_valid,
	input  logic [31:0]    cfg_data,
	input  logic           out_ready,
	input  sshp_pkg::cmd_t cmd,
	output sshp_pkg::sts_t sts,
	output logic           out_valid,
	output logic [2:0]     out_status,
	output logic           out_entry_valid,
	output logic [3:0]     out_index,
	output logic [31:0]    out_offset,
	output logic [31:0]    out_length,
	output logic           out_last
);

	localparam int CW = $clog2(MAX_STREAMS + 1);
	localparam int AW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;

	logic [31:0]   exp_ver_q;
	logic [31:0]   acc_q;
	logic [2:0]    digit_pos_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] seen_q;
	logic [35:0]   sum_q;
	logic [31:0]   header_q;
	logic [32:0]   payload_q;
	logic [2:0]    err_q;
	logic [AW-1:0] emit_pos_q;
	logic [31:0]   offset_q;
	logic [31:0]   rd_q;
	logic [31:0]   len_mem [MAX_STREAMS];

	logic [31:0]   digit;
	logic [31:0]   acc_next;
	logic [35:0]   sum_next;
	logic [32:0]   payload_inc;

	always_comb begin
		case (digit_pos_q)
			3'd0:    digit = {25'd0, data_byte[6:0]};
			3'd1:    digit = {18'd0, data_byte[6:0], 7'd0};
			3'd2:    digit = {11'd0, data_byte[6:0], 14'd0};
			3'd3:    digit = {4'd0, data_byte[6:0], 21'd0};
			default: digit = {data_byte[3:0], 28'd0};
		endcase
		acc_next    = acc_q | digit;
		sum_next    = sum_q + {4'd0, acc_next};
		payload_inc = (payload_q != {33{1'b1}}) ? payload_q + 33'd1 : payload_q;
	end

	assign sts.byte_more    = data_byte[7];
	assign sts.digit_full   = (digit_pos_q >= 3'd4);
	assign sts.version_ok   = (acc_next == exp_ver_q);
	assign sts.count_over   = (acc_next > 32'(MAX_STREAMS));
	assign sts.field_zero   = (acc_next == 32'd0);
	assign sts.lengths_last = ((32'(seen_q) + 32'd1) >= 32'(count_q));
	assign sts.count_zero_q = (count_q == '0);
	assign sts.size_ok_inc  = ({3'd0, payload_inc} == sum_q);
	assign sts.size_ok_len  = (sum_next == {3'd0, payload_q});
	assign sts.emit_last    = ((32'(emit_pos_q) + 32'd1) == 32'(count_q));
	assign sts.out_free     = !out_valid || out_ready;
	assign sts.err_code_q   = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_ver_q <= sshp_pkg::VERSION_RESET;
		end else if (cfg_valid) begin
			exp_ver_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			digit_pos_q <= '0;
			count_q     <= '0;
			seen_q      <= '0;
			sum_q       <= '0;
			header_q    <= '0;
			payload_q   <= '0;
			err_q       <= sshp_pkg::ST_OK;
			emit_pos_q  <= '0;
			offset_q    <= '0;
		end else begin
			if (cmd.take_byte) begin
				header_q <= header_q + 32'd1;
				if (data_byte[7]) begin
					acc_q       <= acc_next;
					digit_pos_q <= digit_pos_q + 3'd1;
				end else begin
					acc_q       <= '0;
					digit_pos_q <= '0;
				end
			end
			if (cmd.take_count) begin
				count_q <= acc_next[CW-1:0];
				seen_q  <= '0;
			end
			if (cmd.take_length) begin
				sum_q  <= sum_next;
				seen_q <= seen_q + CW'(1);
			end
			if (cmd.take_payload) begin
				payload_q <= payload_inc;
			end
			if (cmd.set_err) begin
				err_q <= cmd.err_code;
			end
			// When the last byte closes the header, it still counts toward the offset.
			if (cmd.emit_start) begin
				offset_q   <= header_q + {31'd0, cmd.take_byte};
				emit_pos_q <= '0;
			end
			if (cmd.load_entry) begin
				offset_q   <= offset_q + rd_q;
				emit_pos_q <= emit_pos_q + AW'(1);
			end
			if (cmd.clear_run) begin
				acc_q       <= '0;
				digit_pos_q <= '0;
				count_q     <= '0;
				seen_q      <= '0;
				sum_q       <= '0;
				header_q    <= '0;
				payload_q   <= '0;
				err_q       <= sshp_pkg::ST_OK;
				emit_pos_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_length) begin
			len_mem[seen_q[AW-1:0]] <= acc_next;
		end
		rd_q <= len_mem[emit_pos_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_single || cmd.load_entry) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_single) begin
			out_status      <= cmd.single_code;
			out_entry_valid <= 1'b0;
			out_index       <= '0;
			out_offset      <= '0;
			out_length      <= '0;
			out_last        <= 1'b1;
		end else if (cmd.load_entry) begin
			out_status      <= sshp_pkg::ST_OK;
			out_entry_valid <= 1'b1;
			out_index       <= 4'(emit_pos_q);
			out_offset      <= offset_q;
			out_length      <= rd_q;
			out_last        <= sts.emit_last;
		end
	end

endmodule

[src/stream_set_header_parser_unit.sv]
// Top level of the stream-set header parser: joins controller and datapath
// to the channels. Depends on sshp_pkg, sshp_if, sshp_ctrl and sshp_dp.

// The parser takes one buffer byte per cycle while it reads the header and
// payload or drains a failed buffer, as long as the result register is free
// or is emptied in that same cycle; a sink that holds a result back also
// holds off the input. A last byte that yields a single status result loads
// the result register at the edge that takes it, and the result is offered
// from the next cycle. A good buffer with N streams instead walks the stored
// length table: for each stream entry a registered table read is followed by
// the load of the result register, which waits while that register is full;
// no byte is taken during the walk. The length table needs no clearing pass
// after reset; entries are only read after they were written in the same run.
module stream_set_header_parser_unit #(
	parameter int MAX_STREAMS = 16
) (
	input logic        clk,
	input logic        arst_n,
	sshp_in_if.sink    in_ch,
	sshp_out_if.source out_ch,
	sshp_cfg_if.sink   cfg_ch
);

	sshp_pkg::cmd_t cmd;
	sshp_pkg::sts_t sts;
	logic           in_ready;

	assign in_ch.ready  = in_ready;
	assign cfg_ch.ready = 1'b1;

	sshp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.last_byte (in_ch.last_byte),
		.sts       (sts),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	sshp_dp #(
		.MAX_STREAMS(MAX_STREAMS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.data_byte       (in_ch.data_byte),
		.cfg_valid       (cfg_ch.valid),
		.cfg_data        (cfg_ch.expected_version),
		.out_ready       (out_ch.ready),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_ch.valid),
		.out_status      (out_ch.status),
		.out_entry_valid (out_ch.entry_valid),
		.out_index       (out_ch.stream_index),
		.out_offset      (out_ch.stream_offset),
		.out_length      (out_ch.stream_length),
		.out_last        (out_ch.last)
	);

endmodule

[tb/sv/stream_set_header_parser_unit_tb.sv]
// Self-checking testbench for the stream-set header parser: directed buffers, version sweeps
// and random buffers, with random idling on both channels. Depends on sshp_pkg, the sshp
// channel interfaces and stream_set_header_parser_unit.
module stream_set_header_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STREAM_CAP = 16;
	localparam int SETTLE_CYCLES = 2 * STREAM_CAP + 8;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef enum logic [2:0] {PH_VERSION, PH_COUNT, PH_LENGTHS, PH_PAYLOAD, PH_ERROR} phase_t;
	typedef enum int {BUF_GOOD, BUF_TRUNC, BUF_VERSION, BUF_TOO_MANY, BUF_OVERLONG,
		BUF_MISMATCH, BUF_NOISE} buf_kind_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        entry_valid;
		logic [3:0]  index;
		logic [31:0] offset;
		logic [31:0] length;
		logic        last;
	} stream_result_t;

	typedef logic [7:0] byte_queue_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sshp_in_if  in_ch();
	sshp_out_if out_ch();
	sshp_cfg_if cfg_ch();

	stream_set_header_parser_unit #(.MAX_STREAMS(STREAM_CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	always #1 clk = ~clk;

	// Parser state as the block should hold it.
	logic [31:0]    version_reg;
	phase_t         ph;
	logic [31:0]    acc;
	int unsigned    digits;
	int unsigned    count;
	logic [31:0]    len_tab[STREAM_CAP];
	int unsigned    seen;
	logic [35:0]    len_sum;
	logic [31:0]    hdr_size;
	logic [32:0]    pay_size;
	logic [2:0]     err;

	stream_result_t due_results[$];

	bit src_gaps;
	bit sink_stalls;
	int stall_left;
	int quiet_cycles;
	int errors;
	int bytes_sent;
	int buffers_sent;
	int results_checked;
	int entries_checked;
	int status_seen[8];

	function automatic void clear_run();
		ph = PH_VERSION;
		acc = '0;
		digits = 0;
		count = 0;
		seen = 0;
		len_sum = '0;
		hdr_size = '0;
		pay_size = '0;
		err = sshp_pkg::ST_OK;
	endfunction

	function automatic void fail_run(input logic [2:0] code);
		err = code;
		ph = PH_ERROR;
	endfunction

	function automatic void due_status(input logic [2:0] code);
		due_results.push_back(stream_result_t'{code, 1'b0, 4'd0, 32'd0, 32'd0, 1'b1});
	endfunction

	function automatic void close_field(input logic [31:0] v);
		case (ph)
			PH_VERSION: begin
				if (v != version_reg)
					fail_run(sshp_pkg::ST_VERSION);
				else
					ph = PH_COUNT;
			end
			PH_COUNT: begin
				if (v > STREAM_CAP) begin
					fail_run(sshp_pkg::ST_TOO_MANY);
				end else begin
					count = v;
					seen = 0;
					ph = (v != 0) ? PH_LENGTHS : PH_PAYLOAD;
				end
			end
			default: begin
				if (seen < STREAM_CAP) begin
					len_tab[seen] = v;
					len_sum = len_sum + 36'(v);
					seen++;
				end
				if (seen >= count)
					ph = PH_PAYLOAD;
			end
		endcase
	endfunction

	// Advances the parser by one accepted byte and queues the results it causes.
	function automatic void decode_byte(input logic [7:0] b, input bit fin);
		logic [63:0] digit;
		logic [31:0] field;
		logic [31:0] off;
		if (ph == PH_VERSION || ph == PH_COUNT || ph == PH_LENGTHS) begin
			hdr_size = hdr_size + 32'd1;
			// Digit bits shifted above bit 31 are lost.
			digit = 64'(b[6:0]) << (7 * digits);
			acc = acc | digit[31:0];
			if (b[7]) begin
				if (digits >= 4)
					fail_run(sshp_pkg::ST_OVERLONG);
				else
					digits++;
			end else begin
				field = acc;
				acc = '0;
				digits = 0;
				close_field(field);
			end
		end else if (ph == PH_PAYLOAD && pay_size != '1) begin
			pay_size = pay_size + 33'd1;
		end
		if (!fin)
			return;
		if (ph == PH_ERROR) begin
			due_status(err);
		end else if (ph != PH_PAYLOAD) begin
			due_status(sshp_pkg::ST_TRUNC);
		end else if (36'(pay_size) != len_sum) begin
			due_status(sshp_pkg::ST_MISMATCH);
		end else if (count == 0) begin
			due_status(sshp_pkg::ST_OK);
		end else begin
			off = hdr_size;
			for (int k = 0; k < count; k++) begin
				due_results.push_back(stream_result_t'{sshp_pkg::ST_OK, 1'b1, 4'(k), off,
					len_tab[k], 1'(k + 1 == count)});
				off = off + len_tab[k];
			end
		end
		clear_run();
	endfunction

	// Appends a varint, sometimes padded with extra digits; a fifth digit carries junk
	// in its upper bits, which the parser must drop.
	function automatic void add_varint(ref byte_queue_t q, input logic [31:0] v);
		int need;
		int total;
		logic [7:0] d;
		need = 1;
		while (need < 5 && (v >> (7 * need)) != 0)
			need++;
		total = need;
		if ($urandom_range(0, 5) == 0)
			total = $urandom_range(need, 5);
		for (int i = 0; i < total; i++) begin
			d = {1'b0, 7'(v >> (7 * i))};
			if (i < total - 1)
				d[7] = 1'b1;
			else if (i == 4)
				d[6:4] = 3'($urandom);
			q.push_back(d);
		end
	endfunction

	function automatic void build_buffer(ref byte_queue_t q, input buf_kind_t kind);
		int unsigned n;
		int unsigned cut;
		longint unsigned sum;
		longint unsigned pay;
		logic [31:0] v;
		q.delete();
		case (kind)
			BUF_NOISE: begin
				repeat ($urandom_range(1, 6))
					q.push_back(8'($urandom));
			end
			BUF_OVERLONG: begin
				if ($urandom_range(0, 1)) begin
					add_varint(q, version_reg);
					if ($urandom_range(0, 1))
						add_varint(q, $urandom_range(1, 3));
				end
				repeat (5)
					q.push_back(8'h80 | 8'($urandom));
				repeat ($urandom_range(0, 3))
					q.push_back(8'($urandom));
			end
			BUF_VERSION: begin
				v = version_reg ^ (32'($urandom_range(1, 255)) << $urandom_range(0, 24));
				add_varint(q, v);
				repeat ($urandom_range(0, 3))
					q.push_back(8'($urandom));
			end
			BUF_TOO_MANY: begin
				add_varint(q, version_reg);
				v = $urandom_range(0, 1) ? 32'($urandom_range(STREAM_CAP + 1, 40)) : $urandom;
				if (v <= STREAM_CAP)
					v = v + STREAM_CAP + 1;
				add_varint(q, v);
				repeat ($urandom_range(0, 3))
					q.push_back(8'($urandom));
			end
			default: begin
				case ($urandom_range(0, 9))
					0: n = 0;
					1: n = STREAM_CAP;
					default: n = $urandom_range(1, 4);
				endcase
				add_varint(q, version_reg);
				add_varint(q, n);
				sum = 0;
				for (int k = 0; k < n; k++) begin
					if (kind == BUF_MISMATCH && $urandom_range(0, 3) == 0)
						v = $urandom;
					else
						v = $urandom_range(0, 5);
					add_varint(q, v);
					sum += v;
				end
				if (kind == BUF_TRUNC) begin
					// The last byte falls somewhere inside the header.
					cut = $urandom_range(1, q.size() - 1);
					q = q[0:cut - 1];
				end else begin
					pay = sum;
					if (kind == BUF_MISMATCH) begin
						if (sum > 64)
							pay = $urandom_range(0, 8);
						else if (sum == 0 || $urandom_range(0, 1))
							pay = sum + $urandom_range(1, 3);
						else
							pay = sum - 1;
					end
					repeat (pay)
						q.push_back(8'($urandom));
				end
			end
		endcase
	endfunction

	function automatic buf_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return BUF_GOOD;
		if (r < 63)
			return BUF_TRUNC;
		if (r < 70)
			return BUF_VERSION;
		if (r < 77)
			return BUF_TOO_MANY;
		if (r < 84)
			return BUF_OVERLONG;
		if (r < 93)
			return BUF_MISMATCH;
		return BUF_NOISE;
	endfunction

	task automatic push_byte(input logic [7:0] b, input bit fin);
		if (src_gaps && $urandom_range(0, 9) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.last_byte <= fin;
		do @(posedge clk); while (!in_ch.ready);
		decode_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_buffer(input byte_queue_t q);
		foreach (q[i])
			push_byte(q[i], i == q.size() - 1);
		buffers_sent++;
	endtask

	// Lets every owed result arrive, then gives a table walk time to finish.
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (due_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_version(input logic [31:0] v);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.expected_version <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		version_reg = v;
	endtask

	task automatic test_default_version();
		byte_queue_t q;
		add_varint(q, sshp_pkg::VERSION_RESET);
		q.push_back(8'h01);
		q.push_back(8'h01);
		q.push_back(8'h00);
		send_buffer(q);
	endtask

	// With the version set to zero every special case fits in a few bytes.
	task automatic test_special_cases();
		write_version(32'd0);
		send_buffer('{8'h00, 8'h00});
		send_buffer('{8'h00, 8'h00, 8'hFF});
		send_buffer('{8'h80, 8'h80, 8'h80, 8'h80, 8'hFF});
		send_buffer('{8'h80});
		send_buffer('{8'h00});
		send_buffer('{8'h01});
		send_buffer('{8'h00, 8'h11});
		send_buffer('{8'h00, 8'h01, 8'h02, 8'hFF, 8'h00});
	endtask

	task automatic test_version_extremes();
		logic [31:0] sweep[6];
		byte_queue_t q;
		sweep = '{32'hFFFF_FFFF, 32'h0000_007F, 32'h0000_0080, 32'h1000_0000, $urandom,
			sshp_pkg::VERSION_RESET};
		foreach (sweep[i]) begin
			write_version(sweep[i]);
			build_buffer(q, BUF_GOOD);
			send_buffer(q);
			build_buffer(q, BUF_VERSION);
			send_buffer(q);
			build_buffer(q, pick_kind());
			send_buffer(q);
		end
	endtask

	task automatic test_random_buffers();
		byte_queue_t q;
		int start;
		for (int p = 0; p < 4; p++) begin
			if ($urandom_range(0, 3) == 0)
				write_version(sshp_pkg::VERSION_RESET);
			else
				write_version($urandom >> $urandom_range(0, 31));
			start = bytes_sent;
			while (bytes_sent - start < 40) begin
				// The closing phase runs with both sides at full rate.
				src_gaps = (p < 3) && ($urandom_range(0, 3) != 0);
				sink_stalls = (p < 3) && ($urandom_range(0, 3) != 0);
				build_buffer(q, pick_kind());
				send_buffer(q);
			end
		end
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ch.ready <= 1'b0;
		end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 10);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : result_check
		stream_result_t got;
		stream_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = '{out_ch.status, out_ch.entry_valid, out_ch.stream_index,
				out_ch.stream_offset, out_ch.stream_length, out_ch.last};
			results_checked++;
			if (got.entry_valid)
				entries_checked++;
			status_seen[got.status]++;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result: status %0d valid %0b index %0d offset %0h",
					$time, got.status, got.entry_valid, got.index, got.offset,
					" length %0h last %0b", got.length, got.last);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (got !== want) begin
					$display("%0t: expected status %0d valid %0b index %0d offset %0h",
						$time, want.status, want.entry_valid, want.index, want.offset,
						" length %0h last %0b", want.length, want.last);
					$display("%0t: actual   status %0d valid %0b index %0d offset %0h",
						$time, got.status, got.entry_valid, got.index, got.offset,
						" length %0h last %0b", got.length, got.last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.last_byte = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.expected_version = 32'd0;
		version_reg = sshp_pkg::VERSION_RESET;
		clear_run();
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_default_version();
		test_special_cases();
		test_version_extremes();
		test_random_buffers();
		wait_idle();

		if (due_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, due_results.size());
			errors++;
		end
		$display("Sent %0d buffers (%0d bytes); checked %0d results, %0d of them stream entries.",
			buffers_sent, bytes_sent, results_checked, entries_checked);
		$display("Statuses: ok %0d, truncated %0d, overlong %0d, version %0d, count %0d, size %0d.",
			status_seen[sshp_pkg::ST_OK], status_seen[sshp_pkg::ST_TRUNC],
			status_seen[sshp_pkg::ST_OVERLONG], status_seen[sshp_pkg::ST_VERSION],
			status_seen[sshp_pkg::ST_TOO_MANY], status_seen[sshp_pkg::ST_MISMATCH]);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
src/sshp_pkg.sv
src/sshp_if.sv
src/sshp_ctrl.sv
src/sshp_dp.sv
src/stream_set_header_parser_unit.sv
tb/sv/stream_set_header_parser_unit_tb.sv
